@@ rtl/core/ppts_pkg.sv @@
// shared types and constants for the paper texture shader
`default_nettype none
package ppts_pkg;

  // request payloads
  typedef struct packed {
    logic [11:0] x_pos;
    logic [11:0] y_pos;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_out_t;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_SEED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AGE    = 3'd4;

  // lattice hash multipliers
  localparam logic [31:0] HASH_X  = 32'd374761393;
  localparam logic [31:0] HASH_Y  = 32'd668265263;
  localparam logic [31:0] HASH_S  = 32'd1442695041;
  localparam logic [31:0] HASH_M  = 32'd1274126177;
  localparam logic [31:0] HASH_XY = 32'd1043026656;

  // datapath widths
  localparam int POS_W   = 12;
  localparam int NOISE_W = 19;
  localparam int FBM_W   = 20;
  localparam int MULT_W  = 9;

  // color mix weights in q.12 and base colors
  localparam int W_BROAD  = 9830;
  localparam int W_MEDIUM = 5120;
  localparam int W_FINE   = 2662;
  localparam int W_GREEN  = 3768;
  localparam int W_BLUE   = 3195;
  localparam int BASE_R   = 251;
  localparam int BASE_G   = 249;
  localparam int BASE_B   = 242;

  // pipeline depth by section
  localparam int FRONT_LAT  = 2;
  localparam int OCT_LAT    = 7;
  localparam int LAYER_LAT  = 2;
  localparam int COLOR_LAT  = 3;
  localparam int PIPE_DEPTH = FRONT_LAT + OCT_LAT + LAYER_LAT + COLOR_LAT;

endpackage
`default_nettype wire

@@ rtl/core/ppts_octave.sv @@
// one octave of lattice gradient noise, seven register stages
`default_nettype none
module ppts_octave import ppts_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int MULT      = 7,
  parameter int SEED_ADD  = 0
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [31:0]                seed,
  input  logic [FRAC_BITS+7:0]       nx,
  input  logic [FRAC_BITS+7:0]       ny,
  output logic signed [NOISE_W-1:0]  noise
);

  localparam int NW = FRAC_BITS + 8;
  localparam int PW = NW + MULT_W;
  localparam logic [MULT_W-1:0] MULT_V = MULT_W'(MULT);

  // linear interpolation, weight in q1.15 below one
  function automatic logic signed [NOISE_W-1:0] blend(
    input logic signed [NOISE_W-1:0] a,
    input logic signed [NOISE_W-1:0] b,
    input logic [15:0] w
  );
    logic signed [19:0] df;
    logic signed [36:0] pr;
    logic signed [21:0] rs;
    df = 20'(b) - 20'(a);
    pr = 37'(df) * $signed(37'(w));
    rs = 22'(a) + $signed(pr[36:15]);
    return rs[NOISE_W-1:0];
  endfunction

  // seed term of the hash, follows the seed register
  logic [31:0] sc_r;
  always_ff @(posedge clk) begin
    sc_r <= (seed + 32'(SEED_ADD)) * HASH_S;
  end

  // stage 1: lattice position
  logic [PW-1:0] px_r, py_r, px_nxt, py_nxt;
  assign px_nxt = PW'(nx) * PW'(MULT_V);
  assign py_nxt = PW'(ny) * PW'(MULT_V);

  // stage 2: cell index products, fractions, squares and corner offsets
  logic [31:0] ix, iy;
  logic [14:0] fx, fy;
  logic [29:0] fxx, fyy;
  logic signed [17:0] fsum;
  logic [31:0] ixa_r, iyb_r;
  logic [14:0] t2x_r, t2y_r, fx_r, fy_r;
  logic signed [17:0] d0_r, d1_r, d2_r;

  assign ix = 32'(px_r[PW-1:FRAC_BITS]);
  assign iy = 32'(py_r[PW-1:FRAC_BITS]);
  generate
    if (FRAC_BITS >= 15) begin : g_frac_cut
      assign fx = px_r[FRAC_BITS-1 -: 15];
      assign fy = py_r[FRAC_BITS-1 -: 15];
    end else begin : g_frac_pad
      assign fx = {px_r[FRAC_BITS-1:0], {(15-FRAC_BITS){1'b0}}};
      assign fy = {py_r[FRAC_BITS-1:0], {(15-FRAC_BITS){1'b0}}};
    end
  endgenerate
  assign fxx  = 30'(fx) * 30'(fx);
  assign fyy  = 30'(fy) * 30'(fy);
  assign fsum = $signed(18'(fx)) + $signed(18'(fy));

  // stage 3: corner hashes first round, smoothstep weights
  logic [3:0][31:0] hraw, hx_nxt, hx_r;
  logic [32:0] spx, spy;
  logic [15:0] sx_r, sy_r;
  logic signed [17:0] d0_3_r, d1_3_r, d2_3_r;

  always_comb begin
    hraw[0] = ixa_r + iyb_r + sc_r;
    hraw[1] = hraw[0] + HASH_X;
    hraw[2] = hraw[0] + HASH_Y;
    hraw[3] = hraw[0] + HASH_XY;
    for (int i = 0; i < 4; i++) begin
      hx_nxt[i] = hraw[i] ^ (hraw[i] >> 13);
    end
  end
  assign spx = 33'(t2x_r) * (33'd98304 - 33'({fx_r, 1'b0}));
  assign spy = 33'(t2y_r) * (33'd98304 - 33'({fy_r, 1'b0}));

  // stage 4: corner hashes second multiply
  logic [3:0][31:0] hm_r;
  logic [15:0] sx4_r, sy4_r;
  logic signed [17:0] d0_4_r, d1_4_r, d2_4_r;

  // stage 5: gradients times corner offsets
  logic [3:0][31:0] hf;
  logic [3:0][15:0] gr;
  logic signed [33:0] p0, p1, p2, p3;
  logic signed [NOISE_W-1:0] v0_r, v1_r, v2_r, v3_r;
  logic [15:0] sx5_r, sy5_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      hf[i] = hm_r[i] ^ (hm_r[i] >> 16);
      gr[i] = {~hf[i][30], hf[i][29:15]};
    end
  end
  assign p0 = 34'(d0_4_r) * 34'($signed(gr[0]));
  assign p1 = 34'(d1_4_r) * 34'($signed(gr[1]));
  assign p2 = 34'(d1_4_r) * 34'($signed(gr[2]));
  assign p3 = 34'(d2_4_r) * 34'($signed(gr[3]));

  // stages 6 and 7: blend along x, then along y
  logic signed [NOISE_W-1:0] r0_r, r1_r, n_r;
  logic [15:0] sy6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      ixa_r  <= ix * HASH_X;
      iyb_r  <= iy * HASH_Y;
      t2x_r  <= fxx[29:15];
      t2y_r  <= fyy[29:15];
      fx_r   <= fx;
      fy_r   <= fy;
      d0_r   <= fsum;
      d1_r   <= fsum - 18'sd32768;
      d2_r   <= fsum - 18'sd65536;
      hx_r   <= hx_nxt;
      sx_r   <= spx[30:15];
      sy_r   <= spy[30:15];
      d0_3_r <= d0_r;
      d1_3_r <= d1_r;
      d2_3_r <= d2_r;
      for (int i = 0; i < 4; i++) begin
        hm_r[i] <= hx_r[i] * HASH_M;
      end
      sx4_r  <= sx_r;
      sy4_r  <= sy_r;
      d0_4_r <= d0_3_r;
      d1_4_r <= d1_3_r;
      d2_4_r <= d2_3_r;
      v0_r   <= p0[33:15];
      v1_r   <= p1[33:15];
      v2_r   <= p2[33:15];
      v3_r   <= p3[33:15];
      sx5_r  <= sx4_r;
      sy5_r  <= sy4_r;
      r0_r   <= blend(v0_r, v1_r, sx5_r);
      r1_r   <= blend(v2_r, v3_r, sx5_r);
      sy6_r  <= sy5_r;
      n_r    <= blend(r0_r, r1_r, sy6_r);
    end
  end

  assign noise = n_r;

endmodule
`default_nettype wire

@@ rtl/core/ppts_layer.sv @@
// fractal sum of two or three octaves with the normalizing scale
`default_nettype none
module ppts_layer import ppts_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int OCT       = 3,
  parameter int SCALE     = 7,
  parameter int SEED_OFF  = 0
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [31:0]              seed,
  input  logic [FRAC_BITS+7:0]     nx,
  input  logic [FRAC_BITS+7:0]     ny,
  output logic signed [FBM_W-1:0]  fbm
);

  // scale by 4/7 or 2/3 with floor: offset to positive, reciprocal multiply
  localparam int MSH   = (OCT == 3) ? 2 : 1;
  localparam int OFFS  = (OCT == 3) ? 7 * (2 ** 22) : 3 * (2 ** 22);
  localparam int RSH   = (OCT == 3) ? 29 : 27;
  localparam logic [26:0] RECIP = (OCT == 3) ? 27'd76695845 : 27'd44739243;
  localparam int TOT_W = 21;

  logic signed [NOISE_W-1:0] nz [OCT];

  // one noise unit per octave
  genvar k;
  generate
    for (k = 0; k < OCT; k++) begin : g_oct
      ppts_octave #(
        .FRAC_BITS (FRAC_BITS),
        .MULT      (SCALE << k),
        .SEED_ADD  (SEED_OFF + k)
      ) u_oct (
        .clk   (clk),
        .en    (en),
        .seed  (seed),
        .nx    (nx),
        .ny    (ny),
        .noise (nz[k])
      );
    end
  endgenerate

  // octave sum with halving amplitude
  logic signed [TOT_W-1:0] tot;
  logic signed [25:0] nsum;
  always_comb begin
    tot = '0;
    for (int i = 0; i < OCT; i++) begin
      tot = tot + (TOT_W'(nz[i]) >>> i);
    end
    nsum = (26'(tot) <<< MSH) + 26'(OFFS);
  end

  logic [24:0] m_r;
  logic [51:0] q_r;
  always_ff @(posedge clk) begin
    if (en) begin
      m_r <= nsum[24:0];
      q_r <= 52'(m_r) * 52'(RECIP);
    end
  end

  // remove the offset quotient
  logic signed [23:0] fq;
  assign fq  = $signed({1'b0, q_r[RSH +: 23]}) - 24'sd4194304;
  assign fbm = fq[FBM_W-1:0];

endmodule
`default_nettype wire

@@ rtl/core/ppts_color.sv @@
// grain and ageing mix into the base color, three register stages
`default_nettype none
module ppts_color import ppts_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [FBM_W-1:0]  broad,
  input  logic signed [FBM_W-1:0]  middle,
  input  logic signed [FBM_W-1:0]  fine,
  input  logic signed [FBM_W-1:0]  aged,
  input  logic [15:0]              grain_gain,
  input  logic [15:0]              age_gain,
  output pix_out_t                 rgb
);

  // truncate q15 to integer and clamp to 0..255
  function automatic logic [7:0] clamp8(input logic signed [33:0] v);
    logic [18:0] iv;
    iv = v[33:15];
    if (v < 0) return 8'd0;
    if (iv > 19'd255) return 8'd255;
    return iv[7:0];
  endfunction

  // stage 1: weighted grain sum, age bias
  logic signed [35:0] vs_r;
  logic signed [20:0] age0_r;
  // stage 2: gain products
  logic signed [40:0] vp_r;
  logic signed [37:0] ap_r;
  // stage 3: channel weights
  logic signed [28:0] var2_r;
  logic signed [41:0] gp_r, bp_r;
  logic signed [25:0] age_r;

  logic signed [23:0] var1;
  logic signed [28:0] var2;
  assign var1 = vs_r[35:12];
  assign var2 = vp_r[40:12];

  always_ff @(posedge clk) begin
    if (en) begin
      vs_r   <= 36'(broad) * 36'(W_BROAD) + 36'(middle) * 36'(W_MEDIUM)
              + 36'(fine) * 36'(W_FINE);
      age0_r <= 21'(aged >>> 1) + 21'sd16384;
      vp_r   <= 41'(var1) * $signed(41'(grain_gain));
      ap_r   <= 38'(age0_r) * $signed(38'(age_gain));
      var2_r <= var2;
      gp_r   <= 42'(var2) * 42'(W_GREEN);
      bp_r   <= 42'(var2) * 42'(W_BLUE);
      age_r  <= ap_r[37:12];
    end
  end

  // final sums per channel
  logic signed [33:0] rs, gs, bs;
  assign rs = 34'(BASE_R * 32768) + 34'(var2_r);
  assign gs = 34'(BASE_G * 32768) + 34'(gp_r >>> 12) + 34'(age_r) * 34'sd5;
  assign bs = 34'(BASE_B * 32768) + 34'(bp_r >>> 12) + 34'(age_r) * 34'sd3;

  assign rgb.red   = clamp8(rs);
  assign rgb.green = clamp8(gs);
  assign rgb.blue  = clamp8(bs);

endmodule
`default_nettype wire

@@ rtl/core/procedural_paper_texture_shader.sv @@
// top level of the procedural paper texture shader
//
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_ready  pix_in_t  (x_pos, y_pos)
//  out_     output     out_valid/out_ready  pix_out_t (red, green, blue)
//  cfg_     input      cfg_we               cfg_index, cfg_data
//
// one pixel per clock while the skid is empty; each result runs through the
// 14-stage pipeline (front 2, octave noise 7, fractal sum 2, mix 3)
// reset is synchronous: it empties the pipeline and loads register defaults
// a stalled output holds, one more result parks in a skid register, and only
// then in_ready drops; the whole pipeline freezes while the skid is full
`default_nettype none
module procedural_paper_texture_shader import ppts_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pix_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pix_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CU = (COORD_BITS < POS_W) ? COORD_BITS : POS_W;
  localparam int NW = FRAC_BITS + 8;
  localparam int PRW = CU + 24;

  // configuration registers
  logic [31:0] seed_r;
  logic [23:0] xstep_r, ystep_r;
  logic [15:0] grain_r, age_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r  <= '0;
      xstep_r <= 24'd4096;
      ystep_r <= 24'd4096;
      grain_r <= 16'd4096;
      age_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEED:   seed_r  <= cfg_data;
        REG_X_STEP: xstep_r <= cfg_data[23:0];
        REG_Y_STEP: ystep_r <= cfg_data[23:0];
        REG_GRAIN:  grain_r <= cfg_data[15:0];
        REG_AGE:    age_r   <= cfg_data[15:0];
        default:    ;
      endcase
    end
  end

  // pipeline advance, frozen only while the skid holds a result
  logic skid_v_r;
  logic en;
  assign en       = !skid_v_r;
  assign in_ready = en;

  // valid bits alongside the datapath
  logic [PIPE_DEPTH-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_valid};
    end
  end

  // front: capture position, then normalize
  logic [CU-1:0] xp_r, yp_r;
  logic [NW-1:0] nx_r, ny_r;
  logic [PRW-1:0] xprod, yprod;
  assign xprod = PRW'(xp_r) * PRW'(xstep_r);
  assign yprod = PRW'(yp_r) * PRW'(ystep_r);

  always_ff @(posedge clk) begin
    if (en) begin
      xp_r <= in_data.x_pos[CU-1:0];
      yp_r <= in_data.y_pos[CU-1:0];
      nx_r <= xprod[24-FRAC_BITS +: NW];
      ny_r <= yprod[24-FRAC_BITS +: NW];
    end
  end

  // four fractal layers
  logic signed [FBM_W-1:0] broad, middle, fine, aged;

  ppts_layer #(.FRAC_BITS(FRAC_BITS), .OCT(3), .SCALE(7), .SEED_OFF(0)) u_broad (
    .clk(clk), .en(en), .seed(seed_r), .nx(nx_r), .ny(ny_r), .fbm(broad)
  );
  ppts_layer #(.FRAC_BITS(FRAC_BITS), .OCT(3), .SCALE(24), .SEED_OFF(71)) u_middle (
    .clk(clk), .en(en), .seed(seed_r), .nx(nx_r), .ny(ny_r), .fbm(middle)
  );
  ppts_layer #(.FRAC_BITS(FRAC_BITS), .OCT(2), .SCALE(100), .SEED_OFF(113)) u_fine (
    .clk(clk), .en(en), .seed(seed_r), .nx(nx_r), .ny(ny_r), .fbm(fine)
  );
  ppts_layer #(.FRAC_BITS(FRAC_BITS), .OCT(2), .SCALE(5), .SEED_OFF(200)) u_aged (
    .clk(clk), .en(en), .seed(seed_r), .nx(nx_r), .ny(ny_r), .fbm(aged)
  );

  // color mix
  pix_out_t rgb;
  ppts_color u_color (
    .clk        (clk),
    .en         (en),
    .broad      (broad),
    .middle     (middle),
    .fine       (fine),
    .aged       (aged),
    .grain_gain (grain_r),
    .age_gain   (age_r),
    .rgb        (rgb)
  );

  // output register with skid
  logic     take;
  logic     out_v_r;
  pix_out_t out_d_r, skid_d_r;
  assign take = en && vld_r[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r  <= take;
      end
    end else if (take) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ready) begin
      out_d_r <= skid_v_r ? skid_d_r : rgb;
    end else if (take) begin
      skid_d_r <= rgb;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

endmodule
`default_nettype wire

@@ rtl/core/ppts_checker.sv @@
// port-level checks for the paper texture shader, bound to the top level
`default_nettype none
module ppts_checker import ppts_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input pix_out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // requests are refused only while a result is waiting
  a_ready_backed: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("request refused with empty output");

  // ready drops only after a stalled output cycle
  a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("ready dropped without a stall");

endmodule

bind procedural_paper_texture_shader ppts_checker u_ppts_checker (.*);
`default_nettype wire
